/* rtl/skte_pkg.sv */
// skte_pkg: shared types and codes of the sorted key table engine
`timescale 1ns / 1ps

package skte_pkg;

   localparam int KEY_WIDTH = 32;
   localparam int CMD_W     = 3;
   localparam int CNT_OUT_W = 11;
   localparam int REL_W     = 2;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_DEDUP  = 3'd1,
      CMD_CHECK  = 3'd2,
      CMD_SEARCH = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SORT_REL_MIN = 1'b0,
      CSR_SORT_REL_MAX = 1'b1
   } csr_idx_type;

   typedef logic signed [REL_W-1:0] rel_type;

   localparam rel_type REL_LT = 2'sb11;
   localparam rel_type REL_EQ = 2'sb00;
   localparam rel_type REL_GT = 2'sb01;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [KEY_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [CNT_OUT_W-1:0] position;
      logic [CNT_OUT_W-1:0] entries;
      logic                 in_order;
      logic                 overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SCAN,
      S_RESP
   } state_type;

endpackage

/* rtl/skte_ram.sv */
// skte_ram: generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module skte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/skte_seq.sv */
// skte_seq: command sequencer, entry count, bisection and table walk around the key ram
`timescale 1ns / 1ps

module skte_seq
   import skte_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_payload,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [REL_W-1:0]         csr_wdata,
   output logic                     mem_we,
   output logic [$clog2(DEPTH)-1:0] mem_waddr,
   output logic [KEY_WIDTH-1:0]     mem_wdata,
   output logic [$clog2(DEPTH)-1:0] mem_raddr,
   input  logic [KEY_WIDTH-1:0]     mem_rdata
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 dedup_ff, dedup_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]     end_ff, end_in;
   logic [ADDR_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]     ri_ff, ri_in;
   logic                 dv_ff, dv_in;
   logic [CNT_W-1:0]     di_ff, di_in;
   logic [CNT_W-1:0]     w_ff, w_in;
   logic [KEY_WIDTH-1:0] last_ff, last_in;
   logic                 ok_ff, ok_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   rel_type              rel_min_ff, rel_min_in;
   rel_type              rel_max_ff, rel_max_in;

   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     w_inc;
   rel_type              rel_lo, rel_hi, rel;

   // effective range: any negative minimum means -1, a positive maximum means +1
   assign rel_lo = rel_min_ff[REL_W-1] ? REL_LT : rel_min_ff;
   assign rel_hi = (rel_max_ff == REL_GT) ? REL_GT : rel_max_ff;
   assign rel    = (last_ff < mem_rdata) ? REL_LT :
                   (last_ff > mem_rdata) ? REL_GT : REL_EQ;
   assign mid_sum = {1'b0, start_ff} + {1'b0, end_ff};
   assign w_inc   = w_ff + ONE_C;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      dedup_in     = dedup_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      mid_in       = mid_ff;
      ri_in        = ri_ff;
      dv_in        = dv_ff;
      di_in        = di_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      ok_in        = ok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rel_min_in   = rel_min_ff;
      rel_max_in   = rel_max_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff[ADDR_W-1:0];
      mem_wdata    = key_ff;
      mem_raddr    = '0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SORT_REL_MIN: rel_min_in = rel_type'(csr_wdata);
            CSR_SORT_REL_MAX: rel_max_in = rel_type'(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_payload.key;
               res_in   = '0;
               ri_in    = '0;
               dv_in    = 1'b0;
               w_in     = '0;
               ok_in    = 1'b1;
               start_in = '0;
               end_in   = cnt_ff;
               state_in = S_RESP;
               unique case (req_payload.command)
                  CMD_APPEND: begin
                     if (cnt_ff < DEPTH_C) begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_ff[ADDR_W-1:0];
                        mem_wdata = req_payload.key;
                        cnt_in    = cnt_ff + ONE_C;
                     end else begin
                        res_in.overflow = 1'b1;
                     end
                  end
                  CMD_DEDUP: begin
                     dedup_in = 1'b1;
                     if (cnt_ff > ONE_C) begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_CHECK: begin
                     dedup_in = 1'b0;
                     if (cnt_ff > ONE_C) begin
                        state_in = S_SCAN;
                     end else begin
                        res_in.in_order = 1'b1;
                     end
                  end
                  CMD_SEARCH: state_in = S_SRCH_RD;
                  CMD_CLEAR:  cnt_in   = '0;
                  default: ;
               endcase
            end
         end

         S_SRCH_RD: begin
            if (start_ff < end_ff) begin
               mid_in    = mid_sum[ADDR_W:1];
               mem_raddr = mid_sum[ADDR_W:1];
               state_in  = S_SRCH_CMP;
            end else begin
               res_in.position = CNT_OUT_W'(start_ff);
               state_in        = S_RESP;
            end
         end

         S_SRCH_CMP: begin
            if (key_ff == mem_rdata) begin
               res_in.found    = 1'b1;
               res_in.position = CNT_OUT_W'(mid_ff);
               state_in        = S_RESP;
            end else begin
               if (key_ff > mem_rdata) begin
                  start_in = CNT_W'(mid_ff) + ONE_C;
               end else begin
                  end_in = CNT_W'(mid_ff);
               end
               state_in = S_SRCH_RD;
            end
         end

         S_SCAN: begin
            // reads run ahead of the compare: each entry is compared in the cycle after its read
            dv_in = 1'b0;
            if (ri_ff < cnt_ff) begin
               mem_raddr = ri_ff[ADDR_W-1:0];
               ri_in     = ri_ff + ONE_C;
               dv_in     = 1'b1;
               di_in     = ri_ff;
            end
            if (dv_ff) begin
               last_in = mem_rdata;
               if (di_ff != '0) begin
                  if (dedup_ff) begin
                     // compaction writes land at or behind the entry just read
                     if (mem_rdata != last_ff) begin
                        w_in      = w_inc;
                        mem_we    = 1'b1;
                        mem_waddr = w_inc[ADDR_W-1:0];
                        mem_wdata = mem_rdata;
                     end
                  end else if ((rel < rel_lo) || (rel > rel_hi)) begin
                     ok_in = 1'b0;
                  end
                  if (di_ff == cnt_ff - ONE_C) begin
                     if (dedup_ff) begin
                        cnt_in = w_in + ONE_C;
                     end else begin
                        res_in.in_order = ok_in;
                     end
                     dv_in    = 1'b0;
                     state_in = S_RESP;
                  end
               end
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = res_ff;
               rsp_in.entries = CNT_OUT_W'(cnt_ff);
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         rel_min_ff   <= REL_LT;
         rel_max_ff   <= REL_EQ;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
         rel_min_ff   <= rel_min_in;
         rel_max_ff   <= rel_max_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      dedup_ff <= dedup_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      mid_ff   <= mid_in;
      ri_ff    <= ri_in;
      di_ff    <= di_in;
      w_ff     <= w_in;
      last_ff  <= last_in;
      ok_ff    <= ok_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_append_inc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_payload.command == CMD_APPEND
       && cnt_ff < DEPTH_C) |=> (cnt_ff == $past(cnt_ff) + ONE_C))
      else $error("append did not grow the table by one");

   a_bisect_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH_CMP |-> (start_ff < end_ff && CNT_W'(mid_ff) < end_ff))
      else $error("bisection midpoint outside its window");

   a_compact_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mem_we) |-> (CNT_W'(mem_waddr) <= di_ff))
      else $error("dedup write ahead of the walk");
`endif

endmodule

/* rtl/sorted_key_table_engine_unit.sv */
// sorted_key_table_engine_unit: top level of the sorted key table engine
`timescale 1ns / 1ps
//
//  channel  direction  handshake                   payload
//  req      in         req_valid / req_stall       req_payload  (command, key)
//  rsp      out        rsp_valid / rsp_stall       rsp_payload  (found, position, entries,
//                                                                in_order, overflow)
//  csr      in         csr_write_en                csr_index, csr_wdata
//
//  append, clear and unused commands pass from S_IDLE through S_RESP to the result register
//  search alternates S_SRCH_RD and S_SRCH_CMP once per bisection step, one ram read and
//  one compare per step through one read port, and leaves from S_SRCH_CMP on a hit
//  dedup and the sorted check walk the table at one read per cycle through S_SCAN,
//  and go straight to S_RESP with fewer than two entries
//  reset is synchronous; the key ram is not cleared, only the entry count
//  a new item is taken while a finished result waits, a stalled result holds its slot

module sorted_key_table_engine_unit
   import skte_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REL_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [KEY_WIDTH-1:0] mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [KEY_WIDTH-1:0] mem_rdata;

   skte_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   skte_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule
